// ===== rtl/core/omsk_pkg.sv =====
package omsk_pkg;

   localparam logic [2:0] OP_SET_PIXEL  = 3'd0;
   localparam logic [2:0] OP_GET_PIXEL  = 3'd1;
   localparam logic [2:0] OP_FILL_SPAN  = 3'd2;
   localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
   localparam logic [2:0] OP_INVERT_ALL = 3'd4;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   // one masked byte write toward the store
   typedef struct packed {
      logic       en;
      logic [7:0] mask;
      logic [7:0] data;
   } byte_wr_type;

   // bits lo up to hi (exclusive) of a byte, pixel 0 in the most significant bit
   function automatic logic [7:0] span_mask(input logic [2:0] lo, input logic [3:0] hi);
      logic [7:0] m;
      m = BYTE_ZEROS;
      for (int j = 0; j < 8; j++) begin
         m[7 - j] = (4'(j) >= {1'b0, lo}) && (4'(j) < hi);
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/omsk_mem.sv =====
module omsk_mem
   import omsk_pkg::*;
#(
   parameter int DEPTH = 15000,
   parameter int AW    = 14
) (
   input  logic          clock,
   input  byte_wr_type   wr,
   input  logic [AW-1:0] wr_addr,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int b = 0; b < 8; b++) begin
            if (wr.mask[b]) begin
               mem[wr_addr][b] <= wr.data[b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/omsk_seq.sv =====
module omsk_seq
   import omsk_pkg::*;
#(
   parameter int RASTER_WIDTH  = 400,
   parameter int RASTER_HEIGHT = 300,
   parameter int DEPTH         = 15000,
   parameter int AW            = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic signed [15:0] req_span_end,
   input  logic               req_pixel_color,
   output byte_wr_type        wr,
   output logic [AW-1:0]      wr_addr,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  logic [7:0]         rd_data,
   output logic               res_valid,
   output logic               res_value,
   input  logic               res_ready
);

   localparam int XW = $clog2(RASTER_WIDTH + 1);
   localparam int YW = $clog2(RASTER_HEIGHT + 1);
   localparam int PW = AW + 4;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_ADDR = 3'd2;
   localparam logic [2:0] ST_WALK = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;
   localparam logic [2:0] ST_WIPE = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [XW-1:0] x0_ff, x0_in;
   logic [XW-1:0] x1_ff, x1_in;
   logic [YW-1:0] y_ff, y_in;
   logic          color_ff, color_in;
   logic          inv_ff, inv_in;
   logic          oob_ff, oob_in;
   logic [PW-1:0] base_ff, base_in;
   logic [PW-1:0] p_ff, p_in;
   logic [2:0]    e_ff, e_in;
   logic [AW:0]   lastw_ff, lastw_in;
   logic [AW-1:0] wc_ff, wc_in;

   int            x_i, y_i, e_i, lo_i, hi_i;
   logic          x_ok, y_ok, span_ok, accept;
   logic [AW:0]   word;
   logic          last_word;
   logic [3:0]    hi_bit;
   logic [PW-1:0] end_pos;

   always_comb begin
      x_i     = int'(req_pixel_x);
      y_i     = int'(req_pixel_y);
      e_i     = int'(req_span_end);
      lo_i    = (x_i < 0) ? 0 : x_i;
      hi_i    = (e_i > RASTER_WIDTH) ? RASTER_WIDTH : e_i;
      x_ok    = (x_i >= 0) && (x_i < RASTER_WIDTH);
      y_ok    = (y_i >= 0) && (y_i < RASTER_HEIGHT);
      span_ok = y_ok && (lo_i < hi_i);
      accept  = req_valid && (state_ff == ST_IDLE);

      word      = p_ff[PW-1:3];
      last_word = (word == lastw_ff);
      hi_bit    = (last_word && (e_ff != 3'd0)) ? {1'b0, e_ff} : 4'd8;
      end_pos   = base_ff + PW'(x1_ff);

      state_in = state_ff;
      op_in    = op_ff;
      x0_in    = x0_ff;
      x1_in    = x1_ff;
      y_in     = y_ff;
      color_in = color_ff;
      inv_in   = inv_ff;
      oob_in   = oob_ff;
      base_in  = base_ff;
      p_in     = p_ff;
      e_in     = e_ff;
      lastw_in = lastw_ff;
      wc_in    = wc_ff;

      wr        = '0;
      wr_addr   = p_ff[AW+2:3];
      rd_en     = 1'b0;
      rd_addr   = p_ff[AW+2:3];
      res_valid = 1'b0;
      res_value = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               color_in = req_pixel_color;
               y_in     = YW'(y_i);
               x0_in    = XW'(x_i);
               x1_in    = XW'(x_i + 1);
               oob_in   = 1'b0;
               case (req_opcode)
                  OP_SET_PIXEL: begin
                     if (x_ok && y_ok) state_in = ST_CALC;
                  end
                  OP_GET_PIXEL: begin
                     if (x_ok && y_ok) begin
                        state_in = ST_CALC;
                     end else begin
                        oob_in   = 1'b1;
                        state_in = ST_RESP;
                     end
                  end
                  OP_FILL_SPAN: begin
                     x0_in = XW'(lo_i);
                     x1_in = XW'(hi_i);
                     if (span_ok) state_in = ST_CALC;
                  end
                  OP_CLEAR_ALL: begin
                     inv_in   = 1'b0;
                     wc_in    = '0;
                     state_in = ST_WIPE;
                  end
                  OP_INVERT_ALL: begin
                     inv_in = ~inv_ff;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CALC: begin
            base_in  = PW'(y_ff) * PW'(RASTER_WIDTH);
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            p_in     = base_ff + PW'(x0_ff);
            e_in     = end_pos[2:0];
            lastw_in = (AW+1)'((end_pos - PW'(1)) >> 3);
            state_in = (op_ff == OP_GET_PIXEL) ? ST_READ : ST_WALK;
         end
         ST_WALK: begin
            // one byte per cycle; span and single set share this path
            wr.en   = 1'b1;
            wr.mask = span_mask(p_ff[2:0], hi_bit);
            wr.data = {8{color_ff ^ inv_ff}};
            if (last_word) begin
               state_in = ST_IDLE;
            end else begin
               p_in = {word + 1'b1, 3'b000};
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // read data holds while the result slot is full
            res_valid = 1'b1;
            res_value = oob_ff ? 1'b1 : (rd_data[3'd7 - p_ff[2:0]] ^ inv_ff);
            if (res_ready) state_in = ST_IDLE;
         end
         ST_WIPE: begin
            wr.en   = 1'b1;
            wr.mask = BYTE_ONES;
            wr.data = color_ff ? BYTE_ONES : BYTE_ZEROS;
            wr_addr = wc_ff;
            if (wc_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               wc_in = wc_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         wc_ff    <= '0;
         color_ff <= 1'b1;
         inv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         wc_ff    <= wc_in;
         color_ff <= color_in;
         inv_ff   <= inv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      x0_ff    <= x0_in;
      x1_ff    <= x1_in;
      y_ff     <= y_in;
      oob_ff   <= oob_in;
      base_ff  <= base_in;
      p_ff     <= p_in;
      e_ff     <= e_in;
      lastw_ff <= lastw_in;
   end

endmodule

// ===== rtl/core/one_bit_mask_store.sv =====
// channel  | ports                                                   | dir
// request  | req_valid req_stall req_opcode req_pixel_x req_pixel_y  | in
//          | req_span_end req_pixel_color                            |
// response | rsp_valid rsp_stall rsp_pixel_value                     | out
//
// Set pixel writes one byte; get pixel reads one and waits on the response slot;
// fill span writes each byte touched; clear all writes every byte of the store;
// invert all writes none. A set, span or unused code that writes nothing stays
// idle; an out-of-bounds get answers one. The walker writes through the single port.
// After reset the store is swept to ones, one byte per cycle, with req_stall high;
// a get's result waits in the response register while rsp_stall holds.
module one_bit_mask_store
   import omsk_pkg::*;
#(
   parameter int RASTER_WIDTH  = 400,
   parameter int RASTER_HEIGHT = 300
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic signed [15:0] req_pixel_x,
   input  logic signed [15:0] req_pixel_y,
   input  logic signed [15:0] req_span_end,
   input  logic               req_pixel_color,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_pixel_value
);

   localparam int DEPTH = (RASTER_WIDTH * RASTER_HEIGHT + 7) / 8;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   byte_wr_type   wr;
   logic [AW-1:0] wr_addr;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          res_valid, res_value, res_ready;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_value_ff, rsp_value_in;

   omsk_seq #(
      .RASTER_WIDTH  (RASTER_WIDTH),
      .RASTER_HEIGHT (RASTER_HEIGHT),
      .DEPTH         (DEPTH),
      .AW            (AW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_span_end    (req_span_end),
      .req_pixel_color (req_pixel_color),
      .wr              (wr),
      .wr_addr         (wr_addr),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .res_valid       (res_valid),
      .res_value       (res_value),
      .res_ready       (res_ready)
   );

   omsk_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr      (wr),
      .wr_addr (wr_addr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot frees when empty or its beat leaves this cycle
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;

endmodule
